>>> hdl/vcw_pkg.sv
// Package for the valid-mode 2D convolution window unit.
// Holds sizes, codes and the control structs used by the interfaces, the cell and the top unit; no dependencies.
package vcw_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int MAX_IN_SIZE = 32;
  localparam int DATA_WIDTH  = 16;

  localparam int KK        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = 4;
  localparam int OUT_W     = 36;
  localparam int PROD_W    = 2 * DATA_WIDTH;
  localparam int CNT_W     = $clog2(MAX_IN_SIZE);
  localparam int POS_W     = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
  localparam int LINE_W    = (KERNEL_SIZE - 1) * DATA_WIDTH;

  localparam logic [CFG_W-1:0] IN_SIZE_RST  = CFG_W'(7);
  localparam logic [CFG_W-1:0] OUT_SIZE_RST = CFG_W'(5);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_SIZE  = 1'b0,
    CFG_OUT_SIZE = 1'b1
  } cfg_reg_e;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [OUT_W-1:0]      acc_t;

  typedef struct packed {
    logic                   adv;
    logic                   shift;
    logic [KERNEL_SIZE-1:0] coef_we;
  } cell_ctl_t;

  typedef struct packed {
    logic res;
    logic err;
    logic last;
  } res_ctl_t;

endpackage

>>> hdl/vcw_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on vcw_pkg for the field widths.
interface vcw_in_if;
  import vcw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [IDX_W-1:0]        coef_index;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output action, output coef_index, output value, input ready);
  modport sink (input valid, input action, input coef_index, input value, output ready);
endinterface

interface vcw_out_if;
  import vcw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_value;
  logic                    status;
  logic                    last;

  modport source (output valid, output out_value, output status, output last, input ready);
  modport sink (input valid, input out_value, input status, input last, output ready);
endinterface

>>> hdl/vcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/vcw_cell.sv
// One window column cell: holds a column of pixels and its coefficients,
// passes its column to the left neighbor and forms a registered partial sum.
// Depends on vcw_pkg.
module vcw_cell
  import vcw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  data_t     col_i [KERNEL_SIZE],
  input  data_t     coef_i,
  output data_t     col_o [KERNEL_SIZE],
  output acc_t      sum_o
);

  data_t                    win_q  [KERNEL_SIZE];
  data_t                    coef_q [KERNEL_SIZE];
  logic signed [PROD_W-1:0] prod_q [KERNEL_SIZE];
  acc_t                     sum_d;
  acc_t                     sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        win_q[i] <= '0;
      end
    end else if (ctl_i.adv && ctl_i.shift) begin
      win_q <= col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        if (ctl_i.coef_we[i]) begin
          coef_q[i] <= coef_i;
        end
        prod_q[i] <= win_q[i] * coef_q[i];
      end
      sum_q <= sum_d;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      sum_d = sum_d + OUT_W'(prod_q[i]);
    end
  end

  assign col_o = win_q;
  assign sum_o = sum_q;

endmodule

>>> hdl/valid_conv2d_window_unit.sv
// Streaming valid-mode 2D convolution with a row of window column cells.
// An accepted pixel word passes stages s1 to s4 and the output register before its result.
// Throughput: one word per cycle; the whole pipeline holds while a result waits unread.
// The line store RAM is read at accept and written as the word leaves stage one, with a bypass.
// Reset clears position, reject flag, window and pipeline valids; coefficients are not cleared.
// Depends on vcw_pkg, vcw_if, vcw_ram and vcw_cell.
module valid_conv2d_window_unit
  import vcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  vcw_in_if.sink               in_i,
  vcw_out_if.source            out_o
);

  logic [CFG_W-1:0] in_size_q;
  logic [CFG_W-1:0] out_size_q;
  logic [CNT_W-1:0] row_q;
  logic [CNT_W-1:0] col_q;
  logic             rejected_q;

  logic adv, in_acc, pix_acc, load_acc;
  logic [POS_W-1:0] side, col_p1, row_p1;
  logic col_wrap, row_wrap, first_px, size_bad, reject_now, emit;

  logic             s1_pix_q, s1_load_q;
  data_t            s1_val_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [CNT_W-1:0] s1_col_q;
  res_ctl_t         s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q;

  logic              fwd_hit_q;
  logic [LINE_W-1:0] fwd_word_q;
  logic [LINE_W-1:0] rd_word, line_word, wr_word;
  logic              wr_en;

  data_t     new_col  [KERNEL_SIZE];
  data_t     cell_in  [KERNEL_SIZE][KERNEL_SIZE];
  data_t     cell_out [KERNEL_SIZE][KERNEL_SIZE];
  acc_t      cell_sum [KERNEL_SIZE];
  cell_ctl_t cell_ctl [KERNEL_SIZE];
  acc_t      total;

  logic        out_valid_q;
  acc_t        out_value_q;
  logic        out_status_q;
  logic        out_last_q;

  assign adv      = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && adv;
  assign pix_acc  = in_acc && (in_i.action == ACT_PIXEL);
  assign load_acc = in_acc && (in_i.action == ACT_LOAD);
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q  <= IN_SIZE_RST;
      out_size_q <= OUT_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IN_SIZE:  in_size_q  <= cfg_wdata_i;
        CFG_OUT_SIZE: out_size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_size_q > MAX_IN_SIZE) begin
      side = POS_W'(MAX_IN_SIZE);
    end else if (in_size_q == '0) begin
      side = POS_W'(1);
    end else begin
      side = POS_W'(in_size_q);
    end
    col_p1   = POS_W'(col_q) + POS_W'(1);
    row_p1   = POS_W'(row_q) + POS_W'(1);
    col_wrap = col_p1 >= side;
    row_wrap = row_p1 >= side;
    first_px = (row_q == '0) && (col_q == '0);
    size_bad = (({1'b0, in_size_q} + (CFG_W + 1)'(1)) !=
                ({1'b0, out_size_q} + (CFG_W + 1)'(KERNEL_SIZE))) ||
               (in_size_q < KERNEL_SIZE) || (in_size_q > MAX_IN_SIZE);
    reject_now = !rejected_q && first_px && size_bad;
    emit = (row_p1 >= POS_W'(KERNEL_SIZE)) && (col_p1 >= POS_W'(KERNEL_SIZE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      rejected_q <= 1'b0;
    end else if (pix_acc) begin
      if (col_wrap) begin
        col_q <= '0;
        if (row_wrap) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + CNT_W'(1);
        end
      end else begin
        col_q <= col_q + CNT_W'(1);
      end
      if (col_wrap && row_wrap) begin
        rejected_q <= 1'b0;
      end else if (reject_now) begin
        rejected_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pix_q  <= 1'b0;
      s1_load_q <= 1'b0;
      s1_ctl_q  <= '0;
      s2_ctl_q  <= '0;
      s3_ctl_q  <= '0;
      s4_ctl_q  <= '0;
    end else if (adv) begin
      s1_pix_q      <= pix_acc && !rejected_q && !reject_now;
      s1_load_q     <= load_acc;
      s1_ctl_q.res  <= pix_acc && !rejected_q && (reject_now || emit);
      s1_ctl_q.err  <= reject_now;
      s1_ctl_q.last <= reject_now || (col_wrap && row_wrap);
      s2_ctl_q      <= s1_ctl_q;
      s3_ctl_q      <= s2_ctl_q;
      s4_ctl_q      <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_val_q <= in_i.value;
      s1_idx_q <= in_i.coef_index;
      s1_col_q <= col_q;
    end
  end

  // The row written by the word in stage one is not yet visible to a read of the same column.
  assign wr_en = s1_pix_q && adv;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_hit_q  <= wr_en && (s1_col_q == col_q);
      fwd_word_q <= wr_word;
    end
  end

  vcw_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_IN_SIZE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_col_q),
    .wdata_i (wr_word),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (rd_word)
  );

  always_comb begin
    line_word = fwd_hit_q ? fwd_word_q : rd_word;
    wr_word   = line_word;
    wr_word[DATA_WIDTH-1:0] = s1_val_q;
    for (int s = 1; s < KERNEL_SIZE - 1; s++) begin
      wr_word[s*DATA_WIDTH +: DATA_WIDTH] = line_word[(s-1)*DATA_WIDTH +: DATA_WIDTH];
    end
    for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
      new_col[i] = line_word[(KERNEL_SIZE-2-i)*DATA_WIDTH +: DATA_WIDTH];
    end
    new_col[KERNEL_SIZE-1] = s1_val_q;
  end

  for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_cell
    always_comb begin
      cell_ctl[j].adv   = adv;
      cell_ctl[j].shift = s1_pix_q;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        cell_ctl[j].coef_we[i] = s1_load_q && (s1_idx_q == IDX_W'(i * KERNEL_SIZE + j));
      end
    end

    if (j == KERNEL_SIZE - 1) begin : g_head
      assign cell_in[j] = new_col;
    end else begin : g_link
      assign cell_in[j] = cell_out[j+1];
    end

    vcw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl[j]),
      .col_i  (cell_in[j]),
      .coef_i (s1_val_q),
      .col_o  (cell_out[j]),
      .sum_o  (cell_sum[j])
    );
  end

  always_comb begin
    total = '0;
    for (int j = 0; j < KERNEL_SIZE; j++) begin
      total = total + cell_sum[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_ctl_q.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_value_q  <= s4_ctl_q.err ? '0 : total;
      out_status_q <= s4_ctl_q.err;
      out_last_q   <= s4_ctl_q.last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

endmodule
